/* hw/rtl/brmc_pkg.sv */
// Shared types, constants and the microcode ROM for the balance robot motor controller.
// No dependencies; used by the sequencer, the core and the checker.
`default_nettype none

package brmc_pkg;

	// Fixed point
	localparam int COEFF_FRAC_BITS = 8;
	localparam int FILT_FRAC       = 8;
	localparam int VEL_SHIFT       = COEFF_FRAC_BITS + FILT_FRAC;

	// Datapath widths
	localparam int MUL_W    = 29;
	localparam int PROD_W   = 2 * MUL_W;
	localparam int ACC_W    = 60;
	localparam int X_W      = 28;
	localparam int F_W      = 32;
	localparam int I_W      = 40;
	localparam int I_SPLIT  = 20;
	localparam int BAL_W    = 36 - COEFF_FRAC_BITS;
	localparam int VEL_W    = 32;
	localparam int SUM_W    = 34;
	localparam int DRV_W    = 14;
	localparam int MAG_W    = 13;
	localparam int STEP_W   = 4;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 17;

	// x/5 as x*ceil(2^30/5) >> 30, exact for x < 2^30
	localparam int              RECIP_SHIFT = 30;
	localparam logic [27:0]     RECIP_5     = 28'd214748365;

	// Register reset values
	localparam logic [10:0] RST_ANGLE_OFFSET = 11'd20;
	localparam logic [16:0] RST_BALANCE_KP   = 17'h1FC80;   // -896
	localparam logic [16:0] RST_BALANCE_KD   = 17'h1FF4D;   // -179
	localparam logic [16:0] RST_VELOCITY_KP  = 17'd23040;
	localparam logic [16:0] RST_VELOCITY_KI  = 17'd102;
	localparam logic [12:0] RST_PWM_LIMIT    = 13'd6900;
	localparam logic [14:0] RST_TILT_LIMIT   = 15'd2000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ANGLE_OFFSET    = 4'd0,
		REG_BALANCE_KP      = 4'd1,
		REG_BALANCE_KD      = 4'd2,
		REG_VELOCITY_KP     = 4'd3,
		REG_VELOCITY_KI     = 4'd4,
		REG_PWM_LIMIT       = 4'd5,
		REG_TILT_LIMIT      = 4'd6,
		REG_VELOCITY_ENABLE = 4'd7
	} cfg_reg_t;

	typedef enum logic [1:0] {
		BRIDGE_OFF = 2'd0,
		BRIDGE_FWD = 2'd1,
		BRIDGE_REV = 2'd2
	} bridge_t;

	// Multiplier operand pairs
	typedef enum logic [2:0] {
		MS_KP_DIFF,
		MS_KD_GYRO,
		MS_X_RECIP,
		MS_VKP_F,
		MS_VKI_ILO,
		MS_VKI_IHI
	} mul_sel_t;

	typedef enum logic [1:0] {
		AC_HOLD,
		AC_LOAD,
		AC_ADD,
		AC_ADD_SH
	} acc_op_t;

	typedef enum logic [3:0] {
		AL_NONE,
		AL_LOAD_X,
		AL_ABS_X,
		AL_BAL,
		AL_FILT,
		AL_INTEG,
		AL_VEL,
		AL_SUM,
		AL_CLAMP,
		AL_RUN,
		AL_HALT
	} alu_op_t;

	typedef enum logic [1:0] {
		NX_SEQ,
		NX_JSTOP,
		NX_END
	} next_op_t;

	typedef struct packed {
		mul_sel_t            mul;
		acc_op_t             acc;
		alu_op_t             alu;
		next_op_t            nxt;
		logic [STEP_W-1:0]   target;
	} ctrl_word_t;

	function automatic ctrl_word_t cw(input mul_sel_t m, input acc_op_t a, input alu_op_t l,
		input next_op_t n, input logic [STEP_W-1:0] t);
		ctrl_word_t w;
		w.mul    = m;
		w.acc    = a;
		w.alu    = l;
		w.nxt    = n;
		w.target = t;
		return w;
	endfunction

	// Control program, one word per step
	function automatic ctrl_word_t micro_rom(input logic [STEP_W-1:0] step);
		ctrl_word_t w;
		case (step)
			4'd0:  w = cw(MS_KP_DIFF, AC_HOLD,   AL_LOAD_X, NX_SEQ,   4'd0);
			4'd1:  w = cw(MS_KD_GYRO, AC_LOAD,   AL_ABS_X,  NX_SEQ,   4'd0);
			4'd2:  w = cw(MS_X_RECIP, AC_ADD,    AL_NONE,   NX_SEQ,   4'd0);
			4'd3:  w = cw(MS_X_RECIP, AC_LOAD,   AL_BAL,    NX_SEQ,   4'd0);
			4'd4:  w = cw(MS_X_RECIP, AC_HOLD,   AL_FILT,   NX_SEQ,   4'd0);
			4'd5:  w = cw(MS_X_RECIP, AC_HOLD,   AL_INTEG,  NX_SEQ,   4'd0);
			4'd6:  w = cw(MS_VKP_F,   AC_HOLD,   AL_NONE,   NX_SEQ,   4'd0);
			4'd7:  w = cw(MS_VKI_ILO, AC_LOAD,   AL_NONE,   NX_SEQ,   4'd0);
			4'd8:  w = cw(MS_VKI_IHI, AC_ADD,    AL_NONE,   NX_SEQ,   4'd0);
			4'd9:  w = cw(MS_VKI_IHI, AC_ADD_SH, AL_NONE,   NX_SEQ,   4'd0);
			4'd10: w = cw(MS_VKI_IHI, AC_HOLD,   AL_VEL,    NX_SEQ,   4'd0);
			4'd11: w = cw(MS_VKI_IHI, AC_HOLD,   AL_SUM,    NX_SEQ,   4'd0);
			4'd12: w = cw(MS_VKI_IHI, AC_HOLD,   AL_CLAMP,  NX_SEQ,   4'd0);
			4'd13: w = cw(MS_VKI_IHI, AC_HOLD,   AL_NONE,   NX_JSTOP, 4'd15);
			4'd14: w = cw(MS_VKI_IHI, AC_HOLD,   AL_RUN,    NX_END,   4'd0);
			4'd15: w = cw(MS_VKI_IHI, AC_HOLD,   AL_HALT,   NX_END,   4'd0);
			default: w = cw(MS_KP_DIFF, AC_HOLD, AL_NONE,   NX_END,   4'd0);
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

/* hw/rtl/brmc_seq.sv */
// Microcode sequencer: step counter, control ROM lookup, conditional jump.
// Depends on brmc_pkg.
`default_nettype none

module brmc_seq (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic                  adv,
	input  wire logic                  jump_cond,
	output brmc_pkg::ctrl_word_t       ctrl,
	output logic                       busy
);

	logic [brmc_pkg::STEP_W-1:0] step_q;
	logic                        busy_q;

	assign ctrl = brmc_pkg::micro_rom(step_q);
	assign busy = busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			busy_q <= 1'b0;
		end else if (!busy_q) begin
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end
		end else if (adv) begin
			case (ctrl.nxt)
				brmc_pkg::NX_SEQ:   step_q <= step_q + 1'b1;
				brmc_pkg::NX_JSTOP: step_q <= jump_cond ? ctrl.target : step_q + 1'b1;
				brmc_pkg::NX_END:   busy_q <= 1'b0;
				default:            busy_q <= 1'b0;
			endcase
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/balance_robot_motor_controller_core.sv */
// Balance robot motor controller: PD balance loop, PI velocity loop, clamp and bridge code.
// Depends on brmc_pkg and brmc_seq.
`default_nettype none

// One item at a time: in_stall stays high while the 15-step microcode program runs
// on the shared 29x29 multiplier and accumulator. The last step waits while a previous
// result still sits unclaimed in the output register.
// Reset: registers return to their defaults, filter, integral and held PWM clear,
// the sequencer idles. Config writes are taken in any cycle (cfg_ready stays high).
module balance_robot_motor_controller_core (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	// configuration write channel
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [brmc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  wire logic [brmc_pkg::CFG_DATA_W-1:0]        cfg_data,
	// input channel
	input  wire logic                                   in_valid,
	output logic                                        in_stall,
	input  wire logic signed [15:0]                     tilt_angle,
	input  wire logic signed [15:0]                     gyro_rate,
	input  wire logic signed [15:0]                     left_count,
	input  wire logic signed [15:0]                     right_count,
	// result channel
	output logic                                        out_valid,
	input  wire logic                                   out_stall,
	output logic [brmc_pkg::MAG_W-1:0]                  pwm_magnitude,
	output logic [1:0]                                  bridge_code,
	output logic                                        tilt_stop,
	output logic signed [brmc_pkg::VEL_W-1:0]           velocity_term
);

	localparam int ACC_W   = brmc_pkg::ACC_W;
	localparam int MUL_W   = brmc_pkg::MUL_W;
	localparam int X_W     = brmc_pkg::X_W;
	localparam int F_W     = brmc_pkg::F_W;
	localparam int I_W     = brmc_pkg::I_W;
	localparam int I_SPLIT = brmc_pkg::I_SPLIT;
	localparam int SUM_W   = brmc_pkg::SUM_W;
	localparam int DRV_W   = brmc_pkg::DRV_W;
	localparam int MAG_W   = brmc_pkg::MAG_W;
	localparam int VEL_W   = brmc_pkg::VEL_W;
	localparam int BAL_W   = brmc_pkg::BAL_W;

	// round-toward-zero biases for the two arithmetic right shifts
	localparam logic [ACC_W-1:0] BAL_BIAS =
		(ACC_W'(1) << brmc_pkg::COEFF_FRAC_BITS) - ACC_W'(1);
	localparam logic [ACC_W-1:0] VEL_BIAS =
		(ACC_W'(1) << brmc_pkg::VEL_SHIFT) - ACC_W'(1);

	//--------------------------------------------------------------------------
	// Configuration registers
	//--------------------------------------------------------------------------
	logic signed [10:0] offset_q;
	logic signed [16:0] kp_q, kd_q, vkp_q, vki_q;
	logic [12:0]        pwm_lim_q;
	logic [14:0]        tilt_lim_q;
	logic               vel_en_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q   <= brmc_pkg::RST_ANGLE_OFFSET;
			kp_q       <= brmc_pkg::RST_BALANCE_KP;
			kd_q       <= brmc_pkg::RST_BALANCE_KD;
			vkp_q      <= brmc_pkg::RST_VELOCITY_KP;
			vki_q      <= brmc_pkg::RST_VELOCITY_KI;
			pwm_lim_q  <= brmc_pkg::RST_PWM_LIMIT;
			tilt_lim_q <= brmc_pkg::RST_TILT_LIMIT;
			vel_en_q   <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				brmc_pkg::REG_ANGLE_OFFSET:    offset_q   <= cfg_data[10:0];
				brmc_pkg::REG_BALANCE_KP:      kp_q       <= cfg_data[16:0];
				brmc_pkg::REG_BALANCE_KD:      kd_q       <= cfg_data[16:0];
				brmc_pkg::REG_VELOCITY_KP:     vkp_q      <= cfg_data[16:0];
				brmc_pkg::REG_VELOCITY_KI:     vki_q      <= cfg_data[16:0];
				brmc_pkg::REG_PWM_LIMIT:       pwm_lim_q  <= cfg_data[12:0];
				brmc_pkg::REG_TILT_LIMIT:      tilt_lim_q <= cfg_data[14:0];
				brmc_pkg::REG_VELOCITY_ENABLE: vel_en_q   <= cfg_data[0];
				default: ;  // unknown index: dropped
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Sequencer
	//--------------------------------------------------------------------------
	brmc_pkg::ctrl_word_t ctrl;
	logic                 busy;
	logic                 in_acc;
	logic                 adv;
	logic                 run;
	logic                 stop_now;

	assign in_stall = busy;
	assign in_acc   = in_valid && !in_stall;

	// the final step must not overwrite a result that has not been taken yet
	assign adv = !(ctrl.nxt == brmc_pkg::NX_END && out_valid && out_stall);
	assign run = busy && adv;

	brmc_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (in_acc),
		.adv       (adv),
		.jump_cond (stop_now),
		.ctrl      (ctrl),
		.busy      (busy)
	);

	//--------------------------------------------------------------------------
	// Captured inputs
	//--------------------------------------------------------------------------
	logic signed [15:0] angle_q, gyro_q;
	logic signed [16:0] cnt_sum_q;

	always_ff @(posedge clk) begin
		if (in_acc) begin
			angle_q   <= tilt_angle;
			gyro_q    <= gyro_rate;
			cnt_sum_q <= 17'(left_count) + 17'(right_count);
		end
	end

	logic signed [16:0] angle_diff, angle_ext, tilt_pos, tilt_neg;

	assign angle_diff = 17'(angle_q) - 17'(offset_q);
	assign angle_ext  = 17'(angle_q);
	assign tilt_pos   = 17'({2'b00, tilt_lim_q});
	assign tilt_neg   = -tilt_pos;
	// tilt stop uses the raw angle, not the offset-corrected one
	assign stop_now   = (angle_ext < tilt_neg) || (angle_ext > tilt_pos);

	//--------------------------------------------------------------------------
	// Shared multiplier and accumulator
	//--------------------------------------------------------------------------
	logic signed [X_W-1:0]              x_q;
	logic [X_W-2:0]                     xmag_q;
	logic                               xneg_q;
	logic signed [F_W-1:0]              spd_flt_q;
	logic signed [I_W-1:0]              spd_int_q;
	logic signed [MUL_W-1:0]            mul_a, mul_b;
	logic signed [brmc_pkg::PROD_W-1:0] prod_q;
	logic signed [ACC_W-1:0]            acc_q;

	always_comb begin
		case (ctrl.mul)
			brmc_pkg::MS_KP_DIFF: begin
				mul_a = MUL_W'(kp_q);
				mul_b = MUL_W'(angle_diff);
			end
			brmc_pkg::MS_KD_GYRO: begin
				mul_a = MUL_W'(kd_q);
				mul_b = MUL_W'(gyro_q);
			end
			brmc_pkg::MS_X_RECIP: begin
				mul_a = MUL_W'({1'b0, xmag_q});
				mul_b = MUL_W'({1'b0, brmc_pkg::RECIP_5});
			end
			brmc_pkg::MS_VKP_F: begin
				mul_a = MUL_W'(vkp_q);
				mul_b = MUL_W'(spd_flt_q);
			end
			brmc_pkg::MS_VKI_ILO: begin
				mul_a = MUL_W'(vki_q);
				mul_b = MUL_W'({1'b0, spd_int_q[I_SPLIT-1:0]});
			end
			brmc_pkg::MS_VKI_IHI: begin
				mul_a = MUL_W'(vki_q);
				mul_b = MUL_W'($signed(spd_int_q[I_W-1:I_SPLIT]));
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (run) begin
			prod_q <= mul_a * mul_b;
			case (ctrl.acc)
				brmc_pkg::AC_HOLD:   acc_q <= acc_q;
				brmc_pkg::AC_LOAD:   acc_q <= ACC_W'(prod_q);
				brmc_pkg::AC_ADD:    acc_q <= acc_q + ACC_W'(prod_q);
				// upper half of the integral carries weight 2^I_SPLIT
				brmc_pkg::AC_ADD_SH: acc_q <= acc_q + (ACC_W'(prod_q) <<< I_SPLIT);
				default:             acc_q <= acc_q;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Post-processing on the accumulator
	//--------------------------------------------------------------------------
	logic signed [ACC_W-1:0]   bal_rnd, vel_rnd, vel_shd;
	logic [F_W-1:0]            quot_mag;
	logic signed [I_W:0]       int_sum;
	logic                      int_ovf;
	logic                      vel_fits;
	logic signed [SUM_W-1:0]   lim_pos, lim_neg;
	logic signed [BAL_W-1:0]   bal_q;
	logic signed [VEL_W-1:0]   vel_q;
	logic signed [SUM_W-1:0]   dsum_q;
	logic signed [DRV_W-1:0]   drive_q;
	logic [MAG_W-1:0]          drive_mag;
	logic [MAG_W-1:0]          held_q;

	assign bal_rnd  = acc_q + (acc_q[ACC_W-1] ? BAL_BIAS : ACC_W'(0));
	assign vel_rnd  = acc_q + (acc_q[ACC_W-1] ? VEL_BIAS : ACC_W'(0));
	assign vel_shd  = vel_rnd >>> brmc_pkg::VEL_SHIFT;
	assign vel_fits = (&vel_shd[ACC_W-1:VEL_W-1]) || !(|vel_shd[ACC_W-1:VEL_W-1]);

	// |x| * ceil(2^30/5) >> 30 is floor(|x|/5); sign is put back afterwards
	assign quot_mag = F_W'(acc_q >>> brmc_pkg::RECIP_SHIFT);

	assign int_sum  = (I_W+1)'(spd_int_q) + (I_W+1)'(spd_flt_q);
	assign int_ovf  = int_sum[I_W] != int_sum[I_W-1];

	assign lim_pos  = SUM_W'({1'b0, pwm_lim_q});
	assign lim_neg  = -lim_pos;

	assign drive_mag = drive_q[DRV_W-1] ? MAG_W'(-drive_q) : MAG_W'(drive_q);

	// loop state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spd_flt_q <= '0;
			spd_int_q <= '0;
			held_q    <= '0;
		end else if (run) begin
			case (ctrl.alu)
				brmc_pkg::AL_FILT:  spd_flt_q <= xneg_q ? -quot_mag : quot_mag;
				brmc_pkg::AL_INTEG: spd_int_q <= int_ovf ?
					{int_sum[I_W], {(I_W-1){~int_sum[I_W]}}} : int_sum[I_W-1:0];
				brmc_pkg::AL_RUN:   held_q <= drive_mag;
				default: ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		if (run) begin
			case (ctrl.alu)
				// 4f + 256*(left+right), the numerator of the 0.8/0.2 filter
				brmc_pkg::AL_LOAD_X: x_q <= (X_W'(spd_flt_q) <<< 2)
					+ (X_W'(cnt_sum_q) <<< brmc_pkg::FILT_FRAC);
				brmc_pkg::AL_ABS_X: begin
					xneg_q <= x_q[X_W-1];
					xmag_q <= (X_W-1)'(x_q[X_W-1] ? -x_q : x_q);
				end
				brmc_pkg::AL_BAL:   bal_q <= BAL_W'(bal_rnd >>> brmc_pkg::COEFF_FRAC_BITS);
				brmc_pkg::AL_VEL:   vel_q <= vel_fits ? vel_shd[VEL_W-1:0]
					: {vel_shd[ACC_W-1], {(VEL_W-1){~vel_shd[ACC_W-1]}}};
				brmc_pkg::AL_SUM:   dsum_q <= SUM_W'(bal_q)
					+ (vel_en_q ? SUM_W'(vel_q) : SUM_W'(0));
				brmc_pkg::AL_CLAMP: begin
					if (dsum_q > lim_pos) begin
						drive_q <= DRV_W'(lim_pos);
					end else if (dsum_q < lim_neg) begin
						drive_q <= DRV_W'(lim_neg);
					end else begin
						drive_q <= DRV_W'(dsum_q);
					end
				end
				default: ;
			endcase
		end
	end

	//--------------------------------------------------------------------------
	// Output register
	//--------------------------------------------------------------------------
	logic                      out_valid_q;
	logic [MAG_W-1:0]          mag_q;
	brmc_pkg::bridge_t         code_q;
	logic                      stop_q;
	logic signed [VEL_W-1:0]   vel_out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (run && ctrl.nxt == brmc_pkg::NX_END) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (run) begin
			case (ctrl.alu)
				brmc_pkg::AL_RUN: begin
					mag_q     <= drive_mag;
					code_q    <= drive_q[DRV_W-1] ? brmc_pkg::BRIDGE_REV : brmc_pkg::BRIDGE_FWD;
					stop_q    <= 1'b0;
					vel_out_q <= vel_q;
				end
				// tilted over: bridge off, magnitude held from the last driven tick
				brmc_pkg::AL_HALT: begin
					mag_q     <= held_q;
					code_q    <= brmc_pkg::BRIDGE_OFF;
					stop_q    <= 1'b1;
					vel_out_q <= vel_q;
				end
				default: ;
			endcase
		end
	end

	assign out_valid     = out_valid_q;
	assign pwm_magnitude = mag_q;
	assign bridge_code   = code_q;
	assign tilt_stop     = stop_q;
	assign velocity_term = vel_out_q;

endmodule

`default_nettype wire

/* hw/rtl/brmc_checker.sv */
// Port-level checker for the balance robot motor controller, with its bind.
// Depends on brmc_pkg.
`default_nettype none

module brmc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [12:0] pwm_magnitude,
	input wire logic [1:0]  bridge_code,
	input wire logic        tilt_stop,
	input wire logic [31:0] velocity_term
);

	logic [12:0] last_mag_q;

	// magnitude of the last transaction that actually drove the bridge
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_mag_q <= '0;
		end else if (out_valid && !out_stall && !tilt_stop) begin
			last_mag_q <= pwm_magnitude;
		end
	end

	a_stop_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (tilt_stop == (bridge_code == brmc_pkg::BRIDGE_OFF)))
		else $error("tilt_stop and bridge_code disagree");

	a_stop_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && tilt_stop |-> pwm_magnitude == last_mag_q)
		else $error("stopped transaction did not hold last magnitude");

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while one is in work");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(pwm_magnitude)
			&& $stable(bridge_code) && $stable(tilt_stop) && $stable(velocity_term))
		else $error("stalled result changed");

endmodule

bind balance_robot_motor_controller_core brmc_checker u_brmc_checker (.*);

`default_nettype wire
